>>> hw/rtl/dps_pkg.sv
// Shared types and constants of the distillation phase sequencer.
// No dependencies; the front end, queue, back end and top level import this package.
package dps_pkg;

  // Action codes as they arrive on the input channel
  localparam logic [2:0] ActTick   = 3'd0;
  localparam logic [2:0] ActStart  = 3'd1;
  localparam logic [2:0] ActStop   = 3'd2;
  localparam logic [2:0] ActPause  = 3'd3;
  localparam logic [2:0] ActResume = 3'd4;

  // Phase codes as they leave on the output channel
  localparam logic [2:0] PhaseCodeIdle    = 3'd0;
  localparam logic [2:0] PhaseCodeHeat    = 3'd1;
  localparam logic [2:0] PhaseCodeCollect = 3'd2;
  localparam logic [2:0] PhaseCodeDone    = 3'd3;
  localparam logic [2:0] PhaseCodeError   = 3'd4;

  // Configuration register indexes
  localparam logic [2:0] CfgCollectStart = 3'd0;
  localparam logic [2:0] CfgFinish       = 3'd1;
  localparam logic [2:0] CfgVesselLimit  = 3'd2;
  localparam logic [2:0] CfgWarmupWatts  = 3'd3;
  localparam logic [2:0] CfgCollectWatts = 3'd4;
  localparam logic [2:0] CfgHeadsRate    = 3'd5;
  localparam logic [2:0] CfgBodyRate     = 3'd6;
  localparam logic [2:0] CfgHeadsTarget  = 3'd7;

  localparam logic signed [11:0] RstCollectStart = 12'sd1248;
  localparam logic signed [11:0] RstFinish       = 12'sd1600;
  localparam logic signed [11:0] RstVesselLimit  = 12'sd1632;
  localparam logic [11:0]        RstWarmupWatts  = 12'd2000;
  localparam logic [11:0]        RstCollectWatts = 12'd1000;
  localparam logic [11:0]        RstHeadsRate    = 12'd50;
  localparam logic [11:0]        RstBodyRate     = 12'd500;
  localparam logic [15:0]        RstHeadsTarget  = 16'd0;

  // 50 degrees in 1/16 degree units
  localparam logic signed [11:0] StartMaxTemp = 12'sd800;

  // x / 1000 == (x * DivMagic) >> DivShift for every 32-bit x
  localparam logic [31:0] DivMagic = 32'h10624DD3;
  localparam int unsigned DivShift = 38;

  localparam int unsigned QDepth = 2;

  typedef enum logic [2:0] {
    KindTick,
    KindStart,
    KindStop,
    KindPause,
    KindResume,
    KindNop
  } kind_e;

  typedef enum logic [4:0] {
    PhIdle    = 5'b00001,
    PhHeat    = 5'b00010,
    PhCollect = 5'b00100,
    PhDone    = 5'b01000,
    PhError   = 5'b10000
  } phase_e;

  // Classified transaction handed from front to back
  typedef struct packed {
    kind_e        kind;
    logic [31:0]  now_ms;
    logic [11:0]  vessel_temp;
    logic [11:0]  heat_temp;
    logic         vessel_ok;
    logic         start_ok;
    logic [15:0]  pumped_volume;
  } item_t;

  function automatic logic [2:0] phase_code(phase_e p);
    case (p)
      PhIdle:    return PhaseCodeIdle;
      PhHeat:    return PhaseCodeHeat;
      PhCollect: return PhaseCodeCollect;
      PhDone:    return PhaseCodeDone;
      PhError:   return PhaseCodeError;
      default:   return PhaseCodeIdle;
    endcase
  endfunction

endpackage

>>> hw/rtl/dps_if.sv
// Channel interfaces of the distillation phase sequencer: input items,
// results and configuration writes. No dependencies.
interface dps_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic [31:0]        now_ms;
  logic signed [11:0] vessel_temp;
  logic signed [11:0] product_temp;
  logic               vessel_sensor_ok;
  logic               product_sensor_ok;
  logic [15:0]        pumped_volume;

  modport source (output valid, action, now_ms, vessel_temp, product_temp,
                  vessel_sensor_ok, product_sensor_ok, pumped_volume,
                  input ready);
  modport sink   (input valid, action, now_ms, vessel_temp, product_temp,
                  vessel_sensor_ok, product_sensor_ok, pumped_volume,
                  output ready);
endinterface

interface dps_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase;
  logic        running;
  logic        paused;
  logic        heads_mode;
  logic [11:0] heater_watts;
  logic        valve_open;
  logic [11:0] pump_rate;
  logic        pump_clear;
  logic [31:0] product_total;
  logic [31:0] heads_total;
  logic [22:0] uptime_s;
  logic [22:0] phase_time_s;

  modport source (output valid, phase, running, paused, heads_mode, heater_watts,
                  valve_open, pump_rate, pump_clear, product_total, heads_total,
                  uptime_s, phase_time_s, input ready);
  modport sink   (input valid, phase, running, paused, heads_mode, heater_watts,
                  valve_open, pump_rate, pump_clear, product_total, heads_total,
                  uptime_s, phase_time_s, output ready);
endinterface

interface dps_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/dps_front.sv
// Front end: takes input transactions and classifies them for the back end.
// Depends on dps_pkg and dps_in_if.
module dps_front import dps_pkg::*; (
  dps_in_if.sink   in_i,
  output item_t    item_o,
  output logic     item_valid_o,
  input  logic     item_ready_i
);

  kind_e kind;

  always_comb begin
    case (in_i.action)
      ActTick:   kind = KindTick;
      ActStart:  kind = KindStart;
      ActStop:   kind = KindStop;
      ActPause:  kind = KindPause;
      ActResume: kind = KindResume;
      default:   kind = KindNop;
    endcase
  end

  assign in_i.ready   = item_ready_i;
  assign item_valid_o = in_i.valid;

  always_comb begin
    item_o.kind          = kind;
    item_o.now_ms        = in_i.now_ms;
    item_o.vessel_temp   = in_i.vessel_temp;
    // heating watches the product line when its sensor is there
    item_o.heat_temp     = in_i.product_sensor_ok ? in_i.product_temp
                                                  : in_i.vessel_temp;
    item_o.vessel_ok     = in_i.vessel_sensor_ok;
    item_o.start_ok      = in_i.vessel_sensor_ok && (in_i.vessel_temp <= StartMaxTemp);
    item_o.pumped_volume = in_i.pumped_volume;
  end

endmodule

>>> hw/rtl/dps_queue.sv
// Short FIFO of classified transactions between front and back end.
// Depends on dps_pkg.
module dps_queue import dps_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  item_t wr_item_i,
  input  logic  wr_valid_i,
  output logic  wr_ready_o,
  output item_t rd_item_o,
  output logic  rd_valid_o,
  input  logic  rd_pop_i
);

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  item_t            mem_q [QDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  count_q;
  logic             push, pop;

  assign wr_ready_o = (count_q != CntW'(QDepth));
  assign rd_valid_o = (count_q != '0);
  assign rd_item_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_pop_i && rd_valid_o;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        count_q <= count_q + 1'b1;
      end else if (pop && !push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/dps_back.sv
// Back end: configuration registers, phase state update, shared reciprocal
// multiplier for the two seconds counts, and the result register.
// Depends on dps_pkg, dps_out_if and dps_cfg_if.
module dps_back import dps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dps_cfg_if.sink   cfg_i,
  input  item_t     item_i,
  input  logic      item_valid_i,
  output logic      item_pop_o,
  dps_out_if.source out_o
);

  typedef enum logic [3:0] {
    SeqExec  = 4'b0001,
    SeqMulUp = 4'b0010,
    SeqMulPh = 4'b0100,
    SeqFin   = 4'b1000
  } seq_e;

  // configuration
  logic signed [11:0] cfg_cstart_q, cfg_finish_q, cfg_vlimit_q;
  logic [11:0]        cfg_warm_q, cfg_coll_q, cfg_hrate_q, cfg_brate_q;
  logic [15:0]        cfg_htarget_q;

  // run state
  phase_e             phase_q, phase_d;
  logic               run_q, run_d, pause_q, pause_d, heads_q, heads_d;
  logic [31:0]        run_start_q, run_start_d;
  logic [31:0]        pause_start_q, pause_start_d;
  logic [31:0]        phase_start_q, phase_start_d;
  logic [31:0]        prod_cnt_q, prod_cnt_d, heads_cnt_q, heads_cnt_d;
  logic signed [11:0] lvt_q, lvt_d;
  logic [11:0]        heater_q, heater_d, pump_q, pump_d;
  logic               valve_q, valve_d, clear_q, clear_d;

  // sequencer and divider
  seq_e               seq_q, seq_d;
  logic [31:0]        diff_up_q, diff_up_d, diff_ph_q, diff_ph_d;
  logic [63:0]        mul_q;
  logic [31:0]        mul_a;
  logic [22:0]        up_q;
  logic               out_valid_q, out_load;

  logic signed [11:0] it_vt, it_ht;
  logic [31:0]        base_ms, resume_d;
  logic [32:0]        heads_sum, prod_sum;
  logic [31:0]        heads_sat, prod_sat;
  logic               heads_en, restart_ph, zero_up, exec;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_cstart_q  <= RstCollectStart;
      cfg_finish_q  <= RstFinish;
      cfg_vlimit_q  <= RstVesselLimit;
      cfg_warm_q    <= RstWarmupWatts;
      cfg_coll_q    <= RstCollectWatts;
      cfg_hrate_q   <= RstHeadsRate;
      cfg_brate_q   <= RstBodyRate;
      cfg_htarget_q <= RstHeadsTarget;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CfgCollectStart: cfg_cstart_q  <= cfg_i.data[11:0];
        CfgFinish:       cfg_finish_q  <= cfg_i.data[11:0];
        CfgVesselLimit:  cfg_vlimit_q  <= cfg_i.data[11:0];
        CfgWarmupWatts:  cfg_warm_q    <= cfg_i.data[11:0];
        CfgCollectWatts: cfg_coll_q    <= cfg_i.data[11:0];
        CfgHeadsRate:    cfg_hrate_q   <= cfg_i.data[11:0];
        CfgBodyRate:     cfg_brate_q   <= cfg_i.data[11:0];
        CfgHeadsTarget:  cfg_htarget_q <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign it_vt     = item_i.vessel_temp;
  assign it_ht     = item_i.heat_temp;
  assign heads_en  = (cfg_htarget_q != '0);
  assign exec      = (seq_q == SeqExec) && item_valid_i;
  assign item_pop_o = exec;

  assign heads_sum = {1'b0, heads_cnt_q} + {17'b0, item_i.pumped_volume};
  assign prod_sum  = {1'b0, prod_cnt_q} + {17'b0, item_i.pumped_volume};
  assign heads_sat = heads_sum[32] ? '1 : heads_sum[31:0];
  assign prod_sat  = prod_sum[32] ? '1 : prod_sum[31:0];
  assign resume_d  = item_i.now_ms - pause_start_q;
  // reference instant for elapsed time, before this transaction's update
  assign base_ms   = pause_q ? pause_start_q : item_i.now_ms;

  always_comb begin
    phase_d       = phase_q;
    run_d         = run_q;
    pause_d       = pause_q;
    heads_d       = heads_q;
    run_start_d   = run_start_q;
    pause_start_d = pause_start_q;
    phase_start_d = phase_start_q;
    prod_cnt_d    = prod_cnt_q;
    heads_cnt_d   = heads_cnt_q;
    lvt_d         = lvt_q;
    heater_d      = heater_q;
    pump_d        = pump_q;
    valve_d       = valve_q;
    clear_d       = clear_q;
    restart_ph    = 1'b0;
    zero_up       = 1'b0;

    if (exec) begin
      clear_d = 1'b0;
      case (item_i.kind)
        KindStart: begin
          if (!run_q && item_i.start_ok) begin
            run_start_d   = item_i.now_ms;
            phase_start_d = item_i.now_ms;
            pause_start_d = '0;
            prod_cnt_d    = '0;
            heads_cnt_d   = '0;
            heads_d       = heads_en;
            lvt_d         = it_vt;
            heater_d      = cfg_warm_q;
            valve_d       = 1'b0;
            pump_d        = '0;
            phase_d       = PhHeat;
            run_d         = 1'b1;
            pause_d       = 1'b0;
            restart_ph    = 1'b1;
            zero_up       = 1'b1;
          end
        end
        KindStop: begin
          if (run_q) begin
            heater_d = '0;
            valve_d  = 1'b0;
            pump_d   = '0;
            run_d    = 1'b0;
            pause_d  = 1'b0;
            phase_d  = PhIdle;
          end
        end
        KindPause: begin
          if (run_q && !pause_q) begin
            pause_start_d = item_i.now_ms;
            heater_d      = '0;
            valve_d       = 1'b0;
            pump_d        = '0;
            pause_d       = 1'b1;
          end
        end
        KindResume: begin
          if (run_q && pause_q) begin
            run_start_d   = run_start_q + resume_d;
            phase_start_d = phase_start_q + resume_d;
            case (phase_q)
              PhHeat: heater_d = cfg_warm_q;
              PhCollect: begin
                heater_d = cfg_coll_q;
                valve_d  = 1'b1;
                pump_d   = heads_q ? cfg_hrate_q : cfg_brate_q;
              end
              default: heater_d = '0;
            endcase
            pause_d = 1'b0;
          end
        end
        KindTick: begin
          if (run_q && !pause_q) begin
            // trip on the temperature stored by the previous transaction
            if ((lvt_q > cfg_vlimit_q) || !item_i.vessel_ok) begin
              phase_d       = PhError;
              phase_start_d = item_i.now_ms;
              heater_d      = '0;
              valve_d       = 1'b0;
              pump_d        = '0;
              run_d         = 1'b0;
              pause_d       = 1'b0;
            end else begin
              lvt_d = it_vt;
              case (phase_q)
                PhHeat: begin
                  if (it_ht >= cfg_cstart_q) begin
                    phase_d       = PhCollect;
                    phase_start_d = item_i.now_ms;
                    restart_ph    = 1'b1;
                    heater_d      = cfg_coll_q;
                    valve_d       = 1'b1;
                    heads_d       = heads_en;
                    pump_d        = heads_en ? cfg_hrate_q : cfg_brate_q;
                    clear_d       = 1'b1;
                  end
                end
                PhCollect: begin
                  if (it_vt >= cfg_finish_q) begin
                    heater_d      = '0;
                    valve_d       = 1'b0;
                    pump_d        = '0;
                    phase_d       = PhDone;
                    phase_start_d = item_i.now_ms;
                    restart_ph    = 1'b1;
                  end else if (heads_q && heads_en) begin
                    heads_cnt_d = heads_sat;
                    prod_cnt_d  = prod_sat;
                    if (heads_sat >= {16'b0, cfg_htarget_q}) begin
                      heads_d = 1'b0;
                      clear_d = 1'b1;
                      pump_d  = cfg_brate_q;
                    end
                  end else begin
                    prod_cnt_d = prod_sat;
                  end
                end
                PhDone, PhError: ;
                default: begin
                  heater_d = '0;
                  valve_d  = 1'b0;
                  pump_d   = '0;
                  run_d    = 1'b0;
                  pause_d  = 1'b0;
                  phase_d  = PhIdle;
                end
              endcase
            end
          end
        end
        default: ;
      endcase
    end

    // resume shifts both start marks by the pause length, so the
    // elapsed time seen afterwards is the frozen one
    diff_up_d = zero_up ? '0 : base_ms - run_start_q;
    diff_ph_d = restart_ph ? '0 : base_ms - phase_start_q;
  end

  // sequencer: exec, two passes through the reciprocal multiplier, load
  assign out_load = (seq_q == SeqFin) && (!out_valid_q || out_o.ready);

  always_comb begin
    case (seq_q)
      SeqExec:  seq_d = item_valid_i ? SeqMulUp : SeqExec;
      SeqMulUp: seq_d = SeqMulPh;
      SeqMulPh: seq_d = SeqFin;
      SeqFin:   seq_d = out_load ? SeqExec : SeqFin;
      default:  seq_d = SeqExec;
    endcase
  end

  assign mul_a = (seq_q == SeqMulUp) ? diff_up_q : diff_ph_q;

  always_ff @(posedge clk_i) begin
    if (exec) begin
      diff_up_q <= diff_up_d;
      diff_ph_q <= diff_ph_d;
    end
    if (seq_q == SeqMulUp || seq_q == SeqMulPh) begin
      mul_q <= 64'(mul_a) * 64'(DivMagic);
    end
    if (seq_q == SeqMulPh) begin
      up_q <= mul_q[DivShift+22:DivShift];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q         <= SeqExec;
      phase_q       <= PhIdle;
      run_q         <= 1'b0;
      pause_q       <= 1'b0;
      heads_q       <= 1'b0;
      run_start_q   <= '0;
      pause_start_q <= '0;
      phase_start_q <= '0;
      prod_cnt_q    <= '0;
      heads_cnt_q   <= '0;
      lvt_q         <= '0;
      heater_q      <= '0;
      pump_q        <= '0;
      valve_q       <= 1'b0;
      clear_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      seq_q         <= seq_d;
      phase_q       <= phase_d;
      run_q         <= run_d;
      pause_q       <= pause_d;
      heads_q       <= heads_d;
      run_start_q   <= run_start_d;
      pause_start_q <= pause_start_d;
      phase_start_q <= phase_start_d;
      prod_cnt_q    <= prod_cnt_d;
      heads_cnt_q   <= heads_cnt_d;
      lvt_q         <= lvt_d;
      heater_q      <= heater_d;
      pump_q        <= pump_d;
      valve_q       <= valve_d;
      clear_q       <= clear_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_o.phase         <= phase_code(phase_q);
      out_o.running       <= run_q;
      out_o.paused        <= pause_q;
      out_o.heads_mode    <= heads_q;
      out_o.heater_watts  <= heater_q;
      out_o.valve_open    <= valve_q;
      out_o.pump_rate     <= pump_q;
      out_o.pump_clear    <= clear_q;
      out_o.product_total <= prod_cnt_q;
      out_o.heads_total   <= heads_cnt_q;
      out_o.uptime_s      <= run_q ? up_q : '0;
      out_o.phase_time_s  <= run_q ? mul_q[DivShift+22:DivShift] : '0;
    end
  end

  assign out_o.valid = out_valid_q;

endmodule

>>> hw/rtl/distillation_phase_sequencer.sv
// Distillation phase sequencer, top level.
// An accepted transaction waits in the queue, then the back-end sequencer runs
// exec, both seconds counts through one shared 32x32 reciprocal multiplier, and
// the result load, which waits for the output; then it takes the next transaction.
// Reset: rst_ni asynchronous, active low; phase idle, outputs off, counts zero,
// configuration registers at their defaults. No clearing pass.
module distillation_phase_sequencer import dps_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  dps_cfg_if.sink   cfg_i,
  dps_in_if.sink    in_i,
  dps_out_if.source out_o
);

  item_t front_item, queue_item;
  logic  front_valid, front_ready;
  logic  queue_valid, queue_pop;

  dps_front u_front (
    .in_i         (in_i),
    .item_o       (front_item),
    .item_valid_o (front_valid),
    .item_ready_i (front_ready)
  );

  dps_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_item_i  (front_item),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .rd_item_o  (queue_item),
    .rd_valid_o (queue_valid),
    .rd_pop_i   (queue_pop)
  );

  dps_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_i),
    .item_i       (queue_item),
    .item_valid_i (queue_valid),
    .item_pop_o   (queue_pop),
    .out_o        (out_o)
  );

endmodule
